// ===== hdl/humid_air_heat_capacity_top_assert.svh =====
// Assertion macros for the humid-air heat capacity block.
`ifndef HUMID_AIR_HEAT_CAPACITY_TOP_ASSERT_SVH
`define HUMID_AIR_HEAT_CAPACITY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HAC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hac_pkg.sv =====
// Types, constants and coefficient tables shared by the heat capacity pipeline.
package hac_pkg;

  localparam int TEMP_W      = 17;
  localparam int FRAC_W      = 17;
  localparam int CV_W        = 24;
  localparam int ACC_W       = 37;
  localparam int COEF_W      = 34;
  localparam int WEIGHT_W    = 18;
  localparam int NUM_SPECIES = 3;
  localparam int NUM_TERMS   = 5;
  localparam int NUM_STEPS   = NUM_TERMS - 1;

  localparam int HORNER_SH = 14;
  localparam int DRY_SH    = 16;
  localparam int MIX_SH    = 28;

  localparam int HSUM_W   = ACC_W + TEMP_W + 2;
  localparam int DSUM_W   = ACC_W + WEIGHT_W + 1;
  localparam int MSUM_W   = ACC_W + FRAC_W + 2;
  localparam int MIX_W    = MSUM_W - MIX_SH;

  localparam int HORNER_HALF = 1 << (HORNER_SH - 1);
  localparam int DRY_HALF    = 1 << (DRY_SH - 1);
  localparam int MIX_HALF    = 1 << (MIX_SH - 1);

  localparam logic [TEMP_W-1:0] T_SPLIT  = TEMP_W'(16000);
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  localparam logic signed [WEIGHT_W-1:0] W_N2 = WEIGHT_W'(51773);
  localparam logic signed [WEIGHT_W-1:0] W_O2 = WEIGHT_W'(13763);

  localparam logic signed [MIX_W-1:0] CV_HI = MIX_W'((1 << (CV_W - 1)) - 1);
  localparam logic signed [MIX_W-1:0] CV_LO = MIX_W'(-(1 << (CV_W - 1)));

  typedef enum logic [1:0] {
    SP_N2,
    SP_O2,
    SP_H2O
  } species_t;

  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_SPECIES-1:0]  coef_set_t;

  // One item in flight through the polynomial stages.
  typedef struct packed {
    logic                        vld;
    logic [TEMP_W-1:0]           u;
    logic [FRAC_W-1:0]           y;
    logic                        hi;
    acc_t [NUM_SPECIES-1:0]      acc;
  } stage_t;

  typedef struct packed {
    logic                        vld;
    logic signed [MIX_W-1:0]     mix;
  } mix_t;

  // Coefficients in Q.20, indexed by range, species and power of s.
  localparam coef_t COEF [2][NUM_SPECIES][NUM_TERMS] = '{
    '{
      '{ 34'sd715417123,   34'sd448775707,  -34'sd1293338259,  34'sd1885208330,
        -34'sd836597483 },
      '{ 34'sd758113591,  -34'sd836092054,   34'sd2813345640, -34'sd2832299972,
         34'sd971740301 },
      '{ 34'sd1547879179, -34'sd1009117960,  34'sd3308612529, -34'sd2851564945,
         34'sd942822203 }
    },
    '{
      '{ 34'sd599603808,   34'sd474198228,  -34'sd185513646,   34'sd33740980,
        -34'sd2310910 },
      '{ 34'sd621904797,   34'sd413783019,  -34'sd216548885,   34'sd61281412,
        -34'sd6492326 },
      '{ 34'sd984285220,   34'sd1078732227, -34'sd83254439,   -34'sd50423288,
         34'sd8949525 }
    }
  };

endpackage

// ===== hdl/hac_horner_stage.sv =====
// One Horner step for all three species, with its pipeline register.
module hac_horner_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  hac_pkg::stage_t       d,
  input  hac_pkg::coef_set_t    k,
  output hac_pkg::stage_t       q
);
  import hac_pkg::*;

  logic                   vld;
  logic [TEMP_W-1:0]      u;
  logic [FRAC_W-1:0]      y;
  logic                   hi;
  acc_t [NUM_SPECIES-1:0] acc;
  acc_t [NUM_SPECIES-1:0] acc_next;

  // Multiply, fold the coefficient in above the rounding point, then shift.
  function automatic acc_t horner_step(input acc_t a, input logic [TEMP_W-1:0] s,
                                       input coef_t c);
    logic signed [HSUM_W-1:0] sum;
    sum = HSUM_W'(a * $signed({1'b0, s})) + (HSUM_W'(c) <<< HORNER_SH) + HORNER_HALF;
    return sum[ACC_W+HORNER_SH-1:HORNER_SH];
  endfunction

  always_comb begin
    for (int sp = 0; sp < NUM_SPECIES; sp++) begin
      acc_next[sp] = horner_step(d.acc[sp], d.u, k[sp]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= d.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u   <= d.u;
      y   <= d.y;
      hi  <= d.hi;
      acc <= acc_next;
    end
  end

  assign q = '{vld, u, y, hi, acc};

endmodule

// ===== hdl/hac_mix.sv =====
// Dry-air weighting and vapour mixing, two pipeline stages.
module hac_mix (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  hac_pkg::stage_t   d,
  output hac_pkg::mix_t     q
);
  import hac_pkg::*;

  logic                    dvld;
  logic [FRAC_W-1:0]       dy;
  acc_t                    dry;
  acc_t                    dry_next;
  acc_t                    h2o;
  logic                    mvld;
  logic signed [MIX_W-1:0] mix;
  logic signed [MIX_W-1:0] mix_next;

  function automatic acc_t dry_avg(input acc_t n2, input acc_t o2);
    logic signed [DSUM_W-1:0] sum;
    sum = DSUM_W'(n2 * W_N2) + DSUM_W'(o2 * W_O2) + DRY_HALF;
    return sum[ACC_W+DRY_SH-1:DRY_SH];
  endfunction

  function automatic logic signed [MIX_W-1:0] mix_avg(input acc_t da, input acc_t wv,
                                                      input logic [FRAC_W-1:0] yf);
    logic signed [FRAC_W:0]   wy;
    logic signed [FRAC_W:0]   wd;
    logic signed [MSUM_W-1:0] sum;
    wy  = $signed({1'b0, yf});
    wd  = $signed({1'b0, FRAC_ONE - yf});
    sum = MSUM_W'(da * wd) + MSUM_W'(wv * wy) + MIX_HALF;
    return sum[MSUM_W-1:MIX_SH];
  endfunction

  assign dry_next = dry_avg(d.acc[SP_N2], d.acc[SP_O2]);
  assign mix_next = mix_avg(dry, h2o, dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= 1'b0;
      mvld <= 1'b0;
    end else if (en) begin
      dvld <= d.vld;
      mvld <= dvld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dy  <= d.y;
      dry <= dry_next;
      h2o <= d.acc[SP_H2O];
      mix <= mix_next;
    end
  end

  assign q = '{mvld, mix};

endmodule

// ===== hdl/hac_out_buf.sv =====
// Saturation, output register and skid register on the result side.
module hac_out_buf (
  input  logic                         clk,
  input  logic                         rst,
  input  hac_pkg::mix_t                d,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic signed [hac_pkg::CV_W-1:0] dout,
  output logic                         full
);
  import hac_pkg::*;

  logic                   ov;
  logic signed [CV_W-1:0] od;
  logic                   sv;
  logic signed [CV_W-1:0] sd;
  logic signed [CV_W-1:0] val;
  logic                   push;

  function automatic logic signed [CV_W-1:0] sat(input logic signed [MIX_W-1:0] m);
    logic signed [MIX_W-1:0] c;
    if (m > CV_HI) begin
      c = CV_HI;
    end else if (m < CV_LO) begin
      c = CV_LO;
    end else begin
      c = m;
    end
    return c[CV_W-1:0];
  endfunction

  assign val  = sat(d.mix);
  assign push = d.vld & ~sv;

  // The skid register only fills when a result arrives while the output stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (out_ready) begin
        sv <= 1'b0;
      end
    end else if (push) begin
      if (ov && !out_ready) begin
        sv <= 1'b1;
      end else begin
        ov <= 1'b1;
      end
    end else if (out_ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (out_ready) begin
        od <= sd;
      end
    end else if (push) begin
      if (ov && !out_ready) begin
        sd <= val;
      end else begin
        od <= val;
      end
    end
  end

  assign out_valid = ov;
  assign dout      = od;
  assign full      = sv;

endmodule

// ===== hdl/humid_air_heat_capacity_top.sv =====
// Humid-air Cv pipeline: input register, four Horner stages, dry and mix stages, output.
// Throughput: one item per cycle while the skid register is empty.
// Each Horner stage is a register with one multiply-add per species.
// A stall on the output fills a skid register, which then holds back the whole pipeline.
// Reset clears only the valid bits; in_ready is high from the first cycle after reset.
`include "humid_air_heat_capacity_top_assert.svh"

module humid_air_heat_capacity_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [hac_pkg::TEMP_W-1:0]      temperature,
  input  logic [hac_pkg::FRAC_W-1:0]      vapour_fraction,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [hac_pkg::CV_W-1:0] heat_capacity
);
  import hac_pkg::*;

  logic                   en;
  logic                   full;
  logic                   vld0;
  logic [TEMP_W-1:0]      u0;
  logic [FRAC_W-1:0]      y0;
  logic                   hi0;
  acc_t [NUM_SPECIES-1:0] acc0;
  acc_t [NUM_SPECIES-1:0] acc_init;
  logic                   hi_in;
  logic [FRAC_W-1:0]      y_in;
  stage_t                 st [NUM_STEPS+1];
  coef_set_t              kset [NUM_STEPS];
  mix_t                   mix_q;

  assign en       = ~full;
  assign in_ready = en;

  assign hi_in = (temperature >= T_SPLIT);
  assign y_in  = (vapour_fraction > FRAC_ONE) ? FRAC_ONE : vapour_fraction;

  always_comb begin
    for (int sp = 0; sp < NUM_SPECIES; sp++) begin
      acc_init[sp] = ACC_W'(COEF[hi_in][sp][NUM_TERMS-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0   <= temperature;
      y0   <= y_in;
      hi0  <= hi_in;
      acc0 <= acc_init;
    end
  end

  assign st[0] = '{vld0, u0, y0, hi0, acc0};

  // Each step takes the coefficient one power lower, from the range the item carries.
  always_comb begin
    for (int g = 0; g < NUM_STEPS; g++) begin
      for (int sp = 0; sp < NUM_SPECIES; sp++) begin
        kset[g][sp] = COEF[st[g].hi][sp][NUM_TERMS-2-g];
      end
    end
  end

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
    hac_horner_stage u_step (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (st[g]),
      .k   (kset[g]),
      .q   (st[g+1])
    );
  end

  hac_mix u_mix (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .d   (st[NUM_STEPS]),
    .q   (mix_q)
  );

  hac_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .d         (mix_q),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .dout      (heat_capacity),
    .full      (full)
  );

  `HAC_ASSERT_IMP(a_full_has_out, !in_ready, out_valid, "skid holds a result but output is empty")
  `HAC_ASSERT_NXT(a_mix_reaches_out, mix_q.vld && in_ready, out_valid, "mixed result was dropped")
  `HAC_ASSERT_NXT(a_stall_holds, !in_ready && mix_q.vld, mix_q.vld && $stable(mix_q.mix), "pipeline moved during a stall")
  `HAC_ASSERT_NXT(a_skid_fills, out_valid && !out_ready && mix_q.vld && in_ready, !in_ready, "skid did not take the result")

endmodule

// ===== verif/humid_air_heat_capacity_tb.sv =====
// Self-checking testbench for the humid-air heat capacity pipeline.
`timescale 1ns / 100ps

module testbench;
  import hac_pkg::*;

  localparam int     RANDOM_ITEMS = 400;
  localparam int     PHASE_ITEMS  = 50;
  localparam int     QUIET_LIMIT  = 1000;
  localparam int     TAIL_CYCLES  = 20;
  localparam longint BAND_SPLIT   = 16000;
  localparam longint UNITY        = 65536;
  localparam longint N2_SHARE     = 51773;
  localparam longint O2_SHARE     = 13763;
  localparam longint CV_CEIL      = 8388607;
  localparam longint CV_FLOOR     = -8388608;

  // Polynomial coefficients in Q.20 per band (below / from 1000 K), species and power.
  localparam longint CV_POLY [2][3][5] = '{
    '{
      '{ 715417123,  448775707,   -1293338259,     1885208330,      -836597483 },
      '{ 758113591,  -836092054,  64'sd2813345640, -64'sd2832299972, 971740301 },
      '{ 1547879179, -1009117960, 64'sd3308612529, -64'sd2851564945, 942822203 }
    },
    '{
      '{ 599603808,  474198228,   -185513646,   33740980,    -2310910 },
      '{ 621904797,  413783019,   -216548885,   61281412,    -6492326 },
      '{ 984285220,  1078732227,  -83254439,    -50423288,   8949525 }
    }
  };

  typedef struct packed {
    logic [TEMP_W-1:0]        temp;
    logic [FRAC_W-1:0]        frac;
    logic                     known;
    logic signed [CV_W-1:0]   cv;
  } probe_t;

  // At zero kelvin with pure vapour only the water constant term is left.
  localparam int N_PROBES = 18;
  localparam probe_t PROBES [N_PROBES] = '{
    '{17'd0,      17'd0,      1'b0, 24'sd0},
    '{17'd0,      17'd65536,  1'b1, 24'sd377900},
    '{17'd0,      17'd65537,  1'b1, 24'sd377900},
    '{17'd0,      17'd131071, 1'b1, 24'sd377900},
    '{17'd15984,  17'd0,      1'b0, 24'sd0},
    '{17'd15999,  17'd0,      1'b0, 24'sd0},
    '{17'd15999,  17'd65536,  1'b0, 24'sd0},
    '{17'd16000,  17'd0,      1'b0, 24'sd0},
    '{17'd16000,  17'd65536,  1'b0, 24'sd0},
    '{17'd16016,  17'd32768,  1'b0, 24'sd0},
    '{17'd131071, 17'd0,      1'b0, 24'sd0},
    '{17'd131071, 17'd65536,  1'b0, 24'sd0},
    '{17'd131071, 17'd131071, 1'b0, 24'sd0},
    '{17'd1,      17'd1,      1'b0, 24'sd0},
    '{17'd4800,   17'd6553,   1'b0, 24'sd0},
    '{17'd65535,  17'd32768,  1'b0, 24'sd0},
    '{17'd87381,  17'd43690,  1'b0, 24'sd0},
    '{17'd43690,  17'd87381,  1'b0, 24'sd0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [TEMP_W-1:0]      temperature = '0;
  logic [FRAC_W-1:0]      vapour_fraction = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [CV_W-1:0] heat_capacity;

  logic signed [CV_W-1:0] pending_cv [$];
  int                     error_count = 0;
  bit                     sender_idles = 1'b1;
  bit                     sink_idles = 1'b1;
  int                     sink_stall = 0;
  int                     sink_draw;
  int                     quiet_cycles = 0;

  humid_air_heat_capacity_top uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .temperature     (temperature),
    .vapour_fraction (vapour_fraction),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .heat_capacity   (heat_capacity)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mixture Cv in Q15.8 for one temperature and vapour fraction.
  function automatic logic signed [CV_W-1:0] predict_cv(input logic [TEMP_W-1:0] t,
                                                         input logic [FRAC_W-1:0] y);
    longint u;
    longint share;
    longint cv [3];
    longint dry;
    longint mix;
    int     band;
    u = longint'(t);
    band = (u >= BAND_SPLIT) ? 1 : 0;
    share = (longint'(y) > UNITY) ? UNITY : longint'(y);
    for (int sp = 0; sp < 3; sp++) begin
      cv[sp] = CV_POLY[band][sp][4];
      for (int p = 3; p >= 0; p--) begin
        cv[sp] = ((cv[sp] * u + (longint'(1) <<< 13)) >>> 14) + CV_POLY[band][sp][p];
      end
    end
    dry = (N2_SHARE * cv[SP_N2] + O2_SHARE * cv[SP_O2] + (longint'(1) <<< 15)) >>> 16;
    mix = (dry * (UNITY - share) + cv[SP_H2O] * share + (longint'(1) <<< 27)) >>> 28;
    if (mix > CV_CEIL) mix = CV_CEIL;
    if (mix < CV_FLOOR) mix = CV_FLOOR;
    return mix[CV_W-1:0];
  endfunction

  // Present one item, hold it until the transfer, then record its expected Cv.
  task automatic send_item(input logic [TEMP_W-1:0] t, input logic [FRAC_W-1:0] y,
                           input logic signed [CV_W-1:0] cv);
    int gap;
    gap = sender_idles ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    temperature     <= t;
    vapour_fraction <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_cv.push_back(cv);
  endtask

  // Stop sending and wait until every expected result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cv.size() != 0) @(posedge clk);
  endtask

  // Result side: check every transfer, then draw the stall before the next one.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      sink_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (pending_cv.size() == 0) begin
        $error("heat_capacity: no result expected, got %0d", heat_capacity);
        error_count++;
      end else begin
        if (heat_capacity !== pending_cv[0]) begin
          $error("heat_capacity: expected %0d, actual %0d", pending_cv[0], heat_capacity);
          error_count++;
        end
        void'(pending_cv.pop_front());
      end
      sink_draw = sink_idles ? $urandom_range(0, 15) : 0;
      out_ready  <= (sink_draw == 0);
      sink_stall <= sink_draw;
    end else if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_ready  <= (sink_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TEMP_W-1:0] t;
    logic [FRAC_W-1:0] y;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (PROBES[i]) begin
      send_item(PROBES[i].temp, PROBES[i].frac,
                PROBES[i].known ? PROBES[i].cv : predict_cv(PROBES[i].temp, PROBES[i].frac));
    end
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        // Alternate between full-rate stretches and idling on either side.
        case ($urandom_range(0, 3))
          0: begin sender_idles = 1'b1; sink_idles = 1'b1; end
          1: begin sender_idles = 1'b0; sink_idles = 1'b0; end
          2: begin sender_idles = 1'b1; sink_idles = 1'b0; end
          default: begin sender_idles = 1'b0; sink_idles = 1'b1; end
        endcase
      end
      if (n == RANDOM_ITEMS / 2) wait_drained();
      case ($urandom_range(0, 9)) inside
        [0:3]:   t = TEMP_W'($urandom_range(3200, 56000));
        4:       t = TEMP_W'($urandom_range(15984, 16016));
        5:       t = TEMP_W'($urandom_range(0, 15999));
        6:       t = TEMP_W'($urandom_range(16000, 131071));
        7:       t = TEMP_W'($urandom_range(0, 255));
        default: t = TEMP_W'($urandom_range(0, 131071));
      endcase
      case ($urandom_range(0, 9)) inside
        [0:5]:   y = FRAC_W'($urandom_range(0, 65536));
        6:       y = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
        7:       y = FRAC_W'($urandom_range(65537, 131071));
        8:       y = FRAC_W'($urandom_range(0, 1023));
        default: y = FRAC_W'($urandom_range(0, 131071));
      endcase
      send_item(t, y, predict_cv(t, y));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
